FILE: design/frame_checker_dual_checksum_defines.svh
// Assertion macros shared by the frame checker RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef FRAME_CHECKER_DUAL_CHECKSUM_DEFINES_SVH
`define FRAME_CHECKER_DUAL_CHECKSUM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FCD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// Next-cycle implication, disabled during reset.
`define FCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

FILE: design/fcd_pkg.sv
// Shared types and constants of the frame checker.
// Depends on nothing; used by every module of the block.
`default_nettype none

package fcd_pkg;

  localparam int unsigned MAX_FRAME_LEN_DEFAULT = 1024;

  // Header layout
  localparam int unsigned HDR_TYPE_POS = 5;
  localparam int unsigned HDR_VER_POS  = 6;
  localparam int unsigned BODY_START   = 10;
  localparam int unsigned MIN_LEN_IDX  = 11;
  localparam logic [7:0]  HDR_MAGIC_BASE = 8'hC0;

  // Frame status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_HEADER = 2'd1;
  localparam logic [1:0] ST_TOTAL  = 2'd2;
  localparam logic [1:0] ST_DATA   = 2'd3;

  // Result kinds
  localparam logic KIND_BODY   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Configuration register indexes and reset values
  localparam logic REG_EXPECTED_TYPE    = 1'b0;
  localparam logic REG_EXPECTED_VERSION = 1'b1;
  localparam logic [7:0] EXPECTED_TYPE_RESET    = 8'd3;
  localparam logic [7:0] EXPECTED_VERSION_RESET = 8'd1;

  // Result queue sizing
  localparam int unsigned MAX_RESULTS = 2;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned PUSH_W      = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic       result_kind;
    logic [7:0] body_byte;
    logic [1:0] frame_status;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [PUSH_W-1:0] count;
    result_t           first;
    result_t           second;
  } push_t;

endpackage

`default_nettype wire

FILE: design/fcd_byte_if.sv
// Input channel of the frame checker: one frame byte per word.
// Depends on nothing.
`default_nettype none

interface fcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output end_of_frame, input ready);
  modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

FILE: design/fcd_result_if.sv
// Output channel of the frame checker: a body byte or a frame status per word.
// Depends on nothing.
`default_nettype none

interface fcd_result_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] body_byte;
  logic [1:0] frame_status;
  logic       run_last;

  modport source (output valid, output result_kind, output body_byte,
                  output frame_status, output run_last, input ready);
  modport sink   (input valid, input result_kind, input body_byte,
                  input frame_status, input run_last, output ready);
endinterface

`default_nettype wire

FILE: design/fcd_check.sv
// Frame state and per-byte check logic: header compare, running sums, body hold.
// Depends on fcd_pkg.
`default_nettype none

module fcd_check
  import fcd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_frame,
  input  wire logic [7:0] expected_type,
  input  wire logic [7:0] expected_version,
  output push_t           push
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAME_LEN + 1);

  logic [IDX_W-1:0] byte_index;
  logic             header_good;
  logic [7:0]       total_sum;
  logic [7:0]       data_sum;
  logic [7:0]       held_byte;

  logic       byte_ok;
  logic       emit_body;
  logic [1:0] status;
  result_t    body_res;
  result_t    status_res;

  always_comb begin
    byte_ok = 1'b1;
    if (byte_index < IDX_W'(HDR_TYPE_POS)) begin
      byte_ok = (data_byte == HDR_MAGIC_BASE + {5'b0, byte_index[2:0]});
    end else if (byte_index == IDX_W'(HDR_TYPE_POS)) begin
      byte_ok = (data_byte == expected_type);
    end else if (byte_index == IDX_W'(HDR_VER_POS)) begin
      byte_ok = (data_byte == expected_version);
    end
  end

  assign emit_body = (byte_index >= IDX_W'(MIN_LEN_IDX));

  always_comb begin
    if (!emit_body || !header_good) begin
      status = ST_HEADER;
    end else if (total_sum != data_byte) begin
      status = ST_TOTAL;
    end else if (data_sum != held_byte) begin
      status = ST_DATA;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    body_res.result_kind    = KIND_BODY;
    body_res.body_byte      = held_byte;
    body_res.frame_status   = ST_OK;
    body_res.run_last       = 1'b0;
    status_res.result_kind  = KIND_STATUS;
    status_res.body_byte    = 8'd0;
    status_res.frame_status = status;
    status_res.run_last     = 1'b1;
  end

  always_comb begin
    push.count  = '0;
    push.first  = body_res;
    push.second = status_res;
    if (fire) begin
      if (end_of_frame) begin
        push.count = emit_body ? PUSH_W'(2) : PUSH_W'(1);
        push.first = emit_body ? body_res : status_res;
      end else begin
        push.count = emit_body ? PUSH_W'(1) : PUSH_W'(0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      header_good <= 1'b1;
      total_sum   <= 8'd0;
      data_sum    <= 8'd0;
      held_byte   <= 8'd0;
    end else if (fire) begin
      if (end_of_frame) begin
        byte_index  <= '0;
        header_good <= 1'b1;
        total_sum   <= 8'd0;
        data_sum    <= 8'd0;
        held_byte   <= 8'd0;
      end else begin
        header_good <= header_good & byte_ok;
        total_sum   <= total_sum + data_byte;
        if (emit_body) begin
          data_sum <= data_sum + held_byte;
        end
        if (byte_index >= IDX_W'(BODY_START)) begin
          held_byte <= data_byte;
        end
        if (byte_index < IDX_W'(MAX_FRAME_LEN)) begin
          byte_index <= byte_index + IDX_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/fcd_out_fifo.sv
// Result queue: takes up to two result words a cycle, gives one a cycle while the receiver is ready.
// Depends on fcd_pkg, fcd_result_if and the assertion macro header.
`default_nettype none
`include "frame_checker_dual_checksum_defines.svh"

module fcd_out_fifo
  import fcd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire push_t    push,
  output logic          room,
  fcd_result_if.source  result_out
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_second;
  logic [CNT_W-1:0] count;
  logic             pop;
  result_t          head;

  assign wr_ptr_second = wr_ptr + PTR_W'(1);
  assign pop  = result_out.valid && result_out.ready;
  assign room = (count <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));
  assign head = mem[rd_ptr];

  assign result_out.valid        = (count != '0);
  assign result_out.result_kind  = head.result_kind;
  assign result_out.body_byte    = head.body_byte;
  assign result_out.frame_status = head.frame_status;
  assign result_out.run_last     = head.run_last;

  always_ff @(posedge clk) begin
    if (push.count != '0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == PUSH_W'(2)) begin
      mem[wr_ptr_second] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  `FCD_ASSERT_IMPL(a_push_has_room, clk, rst, push.count != '0, room)
  `FCD_ASSERT_IMPL(a_count_in_range, clk, rst, 1'b1, count <= CNT_W'(FIFO_DEPTH))
  `FCD_ASSERT_NEXT(a_held_word_stays, clk, rst, result_out.valid && !result_out.ready,
                   result_out.valid && $stable(rd_ptr))

endmodule

`default_nettype wire

FILE: design/frame_checker_dual_checksum.sv
// Result words are registered: the words that an accepted byte pushes show once the queue holds them.
// Throughput: one byte per cycle; an end-of-frame byte gives up to two words (body, status),
// so input ready drops while the four-word result queue holds more than two words.
// Reset (synchronous, active high): frame state cleared, queue emptied,
// expected_type back to 3 and expected_version back to 1.
`default_nettype none

module frame_checker_dual_checksum
  import fcd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = MAX_FRAME_LEN_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       write_enable,
  input  wire logic       write_index,
  input  wire logic [7:0] write_data,
  fcd_byte_if.sink        frame_in,
  fcd_result_if.source    result_out
);

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
  logic [7:0] expected_type;
  logic [7:0] expected_version;

  logic  fire;
  logic  room;
  push_t push;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_type    <= EXPECTED_TYPE_RESET;
      expected_version <= EXPECTED_VERSION_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        REG_EXPECTED_TYPE:    expected_type    <= write_data;
        REG_EXPECTED_VERSION: expected_version <= write_data;
        default: ;
      endcase
    end
  end

  // Accept a byte only when the queue can take both words of an end-of-frame byte.
  assign frame_in.ready = room;
  assign fire = frame_in.valid && frame_in.ready;

  // Check the byte against the header, advance the sums and hold the body byte
  // one word late; on end of frame, build the status and clear the frame state.
  fcd_check #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_check (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .data_byte       (frame_in.data_byte),
    .end_of_frame    (frame_in.end_of_frame),
    .expected_type   (expected_type),
    .expected_version(expected_version),
    .push            (push)
  );

  // Register the result words and drain them one per cycle while the receiver is ready.
  fcd_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .result_out(result_out)
  );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking bench for frame_checker_dual_checksum: it streams frames through the input
// channel and checks every body byte and frame status word against a cycle-free predictor.
// Depends on fcd_pkg, fcd_byte_if, fcd_result_if and the frame checker RTL.
`default_nettype none

module testbench;
  import fcd_pkg::*;

  // Run shape: one long frame drives the byte index into saturation;
  // the rest are short and medium frames.
  localparam int ITEM_BUDGET    = 1400;
  localparam int LONG_FRAME_LEN = 1030;
  localparam int HOLD_CYCLES    = 300;
  localparam int RUN_LIMIT      = 5_000_000;

  typedef enum int {
    FAULT_NONE,
    FAULT_MAGIC,
    FAULT_TYPE,
    FAULT_VERSION,
    FAULT_TOTAL,
    FAULT_DATA,
    FAULT_SHORT,
    FAULT_NOISE
  } frame_fault_e;

  // Predicts the result words of the frame checker and checks them in order.
  class deframe_scoreboard;
    logic [15:0] frame_pos;
    bit          header_ok;
    logic [7:0]  total_acc;
    logic [7:0]  data_acc;
    logic [7:0]  delayed_byte;
    logic [7:0]  want_type;
    logic [7:0]  want_version;
    result_t     expected_words[$];
    int          errors;

    function new();
      want_type    = EXPECTED_TYPE_RESET;
      want_version = EXPECTED_VERSION_RESET;
      errors       = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      frame_pos    = '0;
      header_ok    = 1'b1;
      total_acc    = '0;
      data_acc     = '0;
      delayed_byte = '0;
    endfunction

    function void write_register(logic idx, logic [7:0] value);
      if (idx == REG_EXPECTED_TYPE) begin
        want_type = value;
      end else begin
        want_version = value;
      end
    endfunction

    // Emit the byte held back from the previous step.
    function void push_body();
      result_t w;
      w = '{result_kind: KIND_BODY, body_byte: delayed_byte,
            frame_status: ST_OK, run_last: 1'b0};
      expected_words.push_back(w);
    endfunction

    // Note one accepted input word and queue the words it causes.
    function void accept_byte(logic [7:0] b, logic eof);
      result_t    w;
      logic [1:0] verdict;
      if (!eof) begin
        if (frame_pos < HDR_TYPE_POS) begin
          if (b != HDR_MAGIC_BASE + frame_pos[7:0]) header_ok = 1'b0;
        end else if (frame_pos == HDR_TYPE_POS) begin
          if (b != want_type) header_ok = 1'b0;
        end else if (frame_pos == HDR_VER_POS) begin
          if (b != want_version) header_ok = 1'b0;
        end
        if (frame_pos >= BODY_START + 1) begin
          push_body();
          data_acc += delayed_byte;
        end
        if (frame_pos >= BODY_START) delayed_byte = b;
        total_acc += b;
        if (frame_pos < MAX_FRAME_LEN_DEFAULT) frame_pos++;
      end else begin
        // Priority: header (or too short), then total sum, then data sum.
        if (frame_pos < MIN_LEN_IDX || !header_ok) begin
          verdict = ST_HEADER;
        end else if (total_acc != b) begin
          verdict = ST_TOTAL;
        end else if (data_acc != delayed_byte) begin
          verdict = ST_DATA;
        end else begin
          verdict = ST_OK;
        end
        // A short frame gives its status with no trailing body byte.
        if (frame_pos >= MIN_LEN_IDX) push_body();
        w = '{result_kind: KIND_STATUS, body_byte: 8'h00,
              frame_status: verdict, run_last: 1'b1};
        expected_words.push_back(w);
        restart_frame();
      end
    endfunction

    // Check one accepted output word against the oldest expectation.
    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual kind=%0d body=%02h status=%0d last=%0d",
                 $time, got.result_kind, got.body_byte, got.frame_status, got.run_last);
        return;
      end
      want = expected_words.pop_front();
      if (got.result_kind !== want.result_kind || got.body_byte !== want.body_byte ||
          got.frame_status !== want.frame_status || got.run_last !== want.run_last) begin
        errors++;
        $display("%0t: word mismatch: expected kind=%0d body=%02h status=%0d last=%0d, %s",
                 $time, want.result_kind, want.body_byte, want.frame_status,
                 want.run_last,
                 $sformatf("actual kind=%0d body=%02h status=%0d last=%0d",
                           got.result_kind, got.body_byte, got.frame_status,
                           got.run_last));
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       write_enable;
  logic       write_index;
  logic [7:0] write_data;

  fcd_byte_if   frame_in ();
  fcd_result_if result_out ();

  frame_checker_dual_checksum uut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .frame_in     (frame_in),
    .result_out   (result_out)
  );

  deframe_scoreboard sb = new();

  // Bench-side copy of the settings, used only to build well-formed headers.
  logic [7:0] cfg_type    = EXPECTED_TYPE_RESET;
  logic [7:0] cfg_version = EXPECTED_VERSION_RESET;

  logic [7:0] frame_bytes[$];
  int         items_sent   = 0;
  int         burst_left   = 1;
  bit         hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Observe both channels and the register port on every edge. Check output words
  // before noting the input word of the same edge: a byte never answers in its own cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_out.valid && result_out.ready)
        sb.check_word('{result_kind: result_out.result_kind, body_byte: result_out.body_byte,
                        frame_status: result_out.frame_status,
                        run_last: result_out.run_last});
      if (frame_in.valid && frame_in.ready)
        sb.accept_byte(frame_in.data_byte, frame_in.end_of_frame);
      if (write_enable)
        sb.write_register(write_index, write_data);
    end
  end

  // Receiver: switch between stall patterns after a random span, and hold off
  // completely for a long stretch when asked, so the result queue fills up and the
  // block stalls its input.
  initial begin
    int mode;
    int span;
    bit rdy;
    result_out.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 400);
      for (int c = 0; c < span; c++) begin
        if (hold_request) begin
          hold_request = 1'b0;
          result_out.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 1);
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ((c % 3) == 0);
        endcase
        result_out.ready <= rdy;
        @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until accepted; drop valid at the end of a burst
  // and idle for a random gap.
  task automatic send_word(input logic [7:0] b, input logic eof);
    frame_in.valid        <= 1'b1;
    frame_in.data_byte    <= b;
    frame_in.end_of_frame <= eof;
    do @(posedge clk); while (!frame_in.ready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      frame_in.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // Mostly short bursts, now and then a long stretch with no gaps.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
  endtask

  // Stop offering and wait until every expected word has come out, and then idle on
  // for header bytes that leave no word behind.
  task automatic settle_block();
    frame_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_register(input logic idx, input logic [7:0] value);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= value;
    @(posedge clk);
    write_enable <= 1'b0;
    @(posedge clk);
    if (idx == REG_EXPECTED_TYPE) begin
      cfg_type = value;
    end else begin
      cfg_version = value;
    end
  endtask

  // Half the time hit an extreme.
  function automatic logic [7:0] pick_setting();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic reconfigure();
    int which;
    settle_block();
    which = $urandom_range(1, 3);
    if (which[0]) program_register(REG_EXPECTED_TYPE, pick_setting());
    if (which[1]) program_register(REG_EXPECTED_VERSION, pick_setting());
  endtask

  // Build one frame into frame_bytes: header, filler, body, data sum, total sum,
  // then break it as the fault asks.
  task automatic build_frame(input int len, input frame_fault_e fault);
    logic [7:0] acc;
    int         pos;
    frame_bytes.delete();
    if (fault == FAULT_NOISE) begin
      for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    for (int i = 0; i < len; i++) begin
      if (i < 5) begin
        frame_bytes.push_back(HDR_MAGIC_BASE + 8'(i));
      end else if (i == 5) begin
        frame_bytes.push_back(cfg_type);
      end else if (i == 6) begin
        frame_bytes.push_back(cfg_version);
      end else if (fault == FAULT_SHORT || i < len - 2) begin
        frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (fault == FAULT_SHORT) return;
    // Data sum over the body, bytes 10 to len-3.
    acc = '0;
    for (int i = BODY_START; i < len - 2; i++) acc += frame_bytes[i];
    frame_bytes.push_back(acc);
    case (fault)
      FAULT_MAGIC: begin
        pos = $urandom_range(0, 4);
        frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
      end
      FAULT_TYPE:    frame_bytes[5] = frame_bytes[5] ^ 8'($urandom_range(1, 255));
      FAULT_VERSION: frame_bytes[6] = frame_bytes[6] ^ 8'($urandom_range(1, 255));
      FAULT_DATA:    frame_bytes[len - 2] = frame_bytes[len - 2] ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
    acc = '0;
    foreach (frame_bytes[i]) acc += frame_bytes[i];
    if (fault == FAULT_TOTAL) acc ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(acc);
  endtask

  // Send frame_bytes; reprogram the registers just before word split_at if it lies inside.
  task automatic send_frame(input int split_at);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (i == split_at) reconfigure();
      send_word(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  initial begin
    int           len;
    int           roll;
    int           split_at;
    bit           long_sent;
    frame_fault_e fault;

    rst                   <= 1'b1;
    write_enable          <= 1'b0;
    write_index           <= REG_EXPECTED_TYPE;
    write_data            <= 8'h00;
    frame_in.valid        <= 1'b0;
    frame_in.data_byte    <= 8'h00;
    frame_in.end_of_frame <= 1'b0;
    long_sent = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: a lone end-of-frame word, a minimal good frame at the reset settings,
    // and a minimal frame with both a bad magic byte and a bad total (header wins).
    send_word(8'hFF, 1'b1);
    build_frame(12, FAULT_NONE);
    send_frame(-1);
    build_frame(12, FAULT_MAGIC);
    frame_bytes[11] = frame_bytes[11] ^ 8'h01;
    send_frame(-1);

    // Move both registers to their extremes before the random part.
    settle_block();
    program_register(REG_EXPECTED_TYPE, 8'hFF);
    program_register(REG_EXPECTED_VERSION, 8'h00);

    while (items_sent < ITEM_BUDGET) begin
      if (!long_sent && items_sent >= 400) begin
        // Saturate the byte index, and stall the receiver while the frame streams in.
        long_sent = 1'b1;
        build_frame(LONG_FRAME_LEN, FAULT_NONE);
        hold_request = 1'b1;
        send_frame(-1);
        continue;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55)      fault = FAULT_NONE;
      else if (roll < 62) fault = FAULT_MAGIC;
      else if (roll < 67) fault = FAULT_TYPE;
      else if (roll < 72) fault = FAULT_VERSION;
      else if (roll < 80) fault = FAULT_TOTAL;
      else if (roll < 88) fault = FAULT_DATA;
      else if (roll < 94) fault = FAULT_SHORT;
      else                fault = FAULT_NOISE;
      if (fault == FAULT_SHORT) begin
        len = $urandom_range(1, 11);
      end else if (fault == FAULT_NOISE) begin
        len = $urandom_range(1, 30);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 90) : $urandom_range(12, 40);
      end
      // Now and then reprogram: usually between frames, sometimes inside one.
      split_at = -1;
      if ($urandom_range(0, 5) == 0) begin
        if (len > 1 && $urandom_range(0, 2) == 0) begin
          split_at = $urandom_range(1, len - 1);
        end else begin
          reconfigure();
        end
      end
      build_frame(len, fault);
      send_frame(split_at);
    end

    settle_block();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
